// ===== src/ordered_list_insert_delete_core_defines.svh =====
// Assertion macros for the ordered list core.
`ifndef ORDERED_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OLID_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define OLID_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/olid_pkg.sv =====
// Shared constants, types and codes of the ordered list core.
package olid_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int ECOUNT_W = 5;

    typedef enum logic [STATUS_W-1:0] {
        STAT_APPENDED  = 2'd0,
        STAT_DELETED   = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } olid_status_t;

    typedef enum logic {
        FUNC_APPEND = 1'b0,
        FUNC_DELETE = 1'b1
    } olid_func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_APPEND_LINK,
        ST_WALK,
        ST_DONE
    } olid_state_t;

    // Write controls from the sequencer to the slot store.
    typedef struct packed {
        logic              val_we;
        logic [SLOT_W-1:0] val_addr;
        logic              link_we;
        logic [SLOT_W-1:0] link_addr;
        logic [SLOT_W-1:0] link_data;
        logic              free_clr;
        logic              free_set;
        logic [SLOT_W-1:0] free_slot;
    } olid_wr_t;

    // Status from the slot store back to the sequencer.
    typedef struct packed {
        logic              match;
        logic [SLOT_W-1:0] rd_link;
        logic              any_free;
        logic [SLOT_W-1:0] pick;
    } olid_rd_t;

endpackage

// ===== src/olid_slot_store.sv =====
// Value and link stores, free-slot map, lowest-free-slot pick and key compare.
module olid_slot_store (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  olid_pkg::olid_wr_t             wr,
    input  logic [olid_pkg::VALUE_W-1:0]   wr_value,
    input  logic [olid_pkg::SLOT_W-1:0]    rd_addr,
    input  logic [olid_pkg::VALUE_W-1:0]   key,
    output olid_pkg::olid_rd_t             rd
);
    import olid_pkg::*;

    logic [VALUE_W-1:0]  value_store [CAPACITY];
    logic [SLOT_W-1:0]   link_store  [CAPACITY];
    logic [VALUE_W-1:0]  rd_value_reg;
    logic [SLOT_W-1:0]   rd_link_reg;
    logic [CAPACITY-1:0] free_map_reg;
    logic [CAPACITY-1:0] free_map_next;

    // rd_addr is the slot of the coming cycle; read data lines up with it
    always_ff @(posedge aclk) begin
        if (wr.val_we) begin
            value_store[wr.val_addr] <= wr_value;
        end
        if (wr.link_we) begin
            link_store[wr.link_addr] <= wr.link_data;
        end
        rd_value_reg <= value_store[rd_addr];
        rd_link_reg  <= link_store[rd_addr];
    end

    always_comb begin
        free_map_next = free_map_reg;
        if (wr.free_clr) begin
            free_map_next[wr.free_slot] = 1'b0;
        end
        if (wr.free_set) begin
            free_map_next[wr.free_slot] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_map_reg <= '1;
        end else begin
            free_map_reg <= free_map_next;
        end
    end

    // Priority pick: scan down so the lowest free slot wins.
    always_comb begin
        rd.pick = '0;
        for (int s = CAPACITY - 1; s >= 0; s--) begin
            if (free_map_reg[s]) begin
                rd.pick = SLOT_W'(s);
            end
        end
        rd.any_free = |free_map_reg;
        rd.match    = (rd_value_reg == key);
        rd.rd_link  = rd_link_reg;
    end

endmodule

// ===== src/ordered_list_insert_delete_core.sv =====
// Top level of the ordered circular list core: sequencer, output register, checks.
//
// Keeps an ordered circular list of up to 16 signed 32-bit values in a slot store
// linked by next-slot pointers. Each beat in (func, value) appends at the tail or
// deletes the first entry equal to value, searching from the head; each gives one
// beat out with status and entry count. An append picks the lowest free slot and writes
// its value and a link in the append state; when the list was not empty, a second
// link write in the append-link state closes the ring. A delete walks the list one
// entry per cycle through a single store read port and one 32-bit compare, stopping
// at a match or once every entry is checked. s_ready is high only in idle; a
// finished result sits in the output register while the next beat is accepted.
// The slot store has no reset or clearing pass; only the free-slot map is reset.
`include "ordered_list_insert_delete_core_defines.svh"

module ordered_list_insert_delete_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_func,
    input  logic signed [olid_pkg::VALUE_W-1:0]  s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [olid_pkg::STATUS_W-1:0]        m_status,
    output logic [olid_pkg::ECOUNT_W-1:0]        m_entry_count
);
    import olid_pkg::*;

    olid_state_t         state_reg, state_next;
    logic                func_reg;
    logic [VALUE_W-1:0]  key_reg;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [SLOT_W-1:0]   tail_reg, tail_next;
    logic [COUNT_W-1:0]  occupancy_reg, occupancy_next;
    logic [SLOT_W-1:0]   cur_reg, cur_next;
    logic [SLOT_W-1:0]   prev_reg, prev_next;
    logic [SLOT_W-1:0]   pick_reg, pick_next;
    logic [COUNT_W-1:0]  walk_reg, walk_next;
    olid_status_t        res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [ECOUNT_W-1:0] m_count_reg, m_count_next;

    logic                accept;
    logic                out_free;
    olid_wr_t            wr;
    olid_rd_t            rd;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    olid_slot_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .wr_value (key_reg),
        .rd_addr  (cur_next),
        .key      (key_reg),
        .rd       (rd)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_func == FUNC_DELETE) ? ST_WALK : ST_APPEND;
                end
            end
            ST_APPEND: begin
                if ((occupancy_reg >= COUNT_W'(CAPACITY)) || !rd.any_free
                        || (occupancy_reg == '0)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_APPEND_LINK;
                end
            end
            ST_APPEND_LINK: state_next = ST_DONE;
            ST_WALK: begin
                if ((walk_reg == occupancy_reg) || rd.match) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and store controls.
    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        occupancy_next = occupancy_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        pick_next      = pick_reg;
        walk_next      = walk_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_count_next   = m_count_reg;
        wr             = '0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cur_next  = head_reg;
                prev_next = tail_reg;
                walk_next = '0;
            end
            ST_APPEND: begin
                if ((occupancy_reg >= COUNT_W'(CAPACITY)) || !rd.any_free) begin
                    res_next = STAT_FULL;
                end else begin
                    res_next       = STAT_APPENDED;
                    pick_next      = rd.pick;
                    wr.val_we      = 1'b1;
                    wr.val_addr    = rd.pick;
                    wr.free_clr    = 1'b1;
                    wr.free_slot   = rd.pick;
                    wr.link_we     = 1'b1;
                    wr.link_data   = rd.pick;
                    if (occupancy_reg == '0) begin
                        wr.link_addr   = rd.pick;
                        head_next      = rd.pick;
                        tail_next      = rd.pick;
                        occupancy_next = occupancy_reg + 1'b1;
                    end else begin
                        wr.link_addr = tail_reg;
                    end
                end
            end
            ST_APPEND_LINK: begin
                // close the ring: new tail points back at the head
                wr.link_we     = 1'b1;
                wr.link_addr   = pick_reg;
                wr.link_data   = head_reg;
                tail_next      = pick_reg;
                occupancy_next = occupancy_reg + 1'b1;
            end
            ST_WALK: begin
                if (walk_reg == occupancy_reg) begin
                    res_next = STAT_NOT_FOUND;
                end else if (rd.match) begin
                    res_next       = STAT_DELETED;
                    wr.free_set    = 1'b1;
                    wr.free_slot   = cur_reg;
                    occupancy_next = occupancy_reg - 1'b1;
                    if (occupancy_reg == COUNT_W'(1)) begin
                        head_next = '0;
                        tail_next = '0;
                    end else begin
                        wr.link_we   = 1'b1;
                        wr.link_addr = prev_reg;
                        wr.link_data = rd.rd_link;
                        if (cur_reg == head_reg) begin
                            head_next = rd.rd_link;
                        end
                        if (cur_reg == tail_reg) begin
                            tail_next = prev_reg;
                        end
                    end
                end else begin
                    prev_next = cur_reg;
                    cur_next  = rd.rd_link;
                    walk_next = walk_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_reg;
                    m_count_next  = ECOUNT_W'(occupancy_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occupancy_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occupancy_reg <= occupancy_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_func;
            key_reg  <= s_value;
        end
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        pick_reg     <= pick_next;
        walk_reg     <= walk_next;
        res_reg      <= res_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

    `OLID_ASSERT_IMP(a_occ_bound, aclk, aresetn, 1'b1,
        occupancy_reg <= COUNT_W'(CAPACITY), "occupancy above capacity")
    `OLID_ASSERT_IMP(a_walk_bound, aclk, aresetn, state_reg == ST_WALK,
        walk_reg <= occupancy_reg, "walk ran past the list")
    `OLID_ASSERT_IMP(a_full_only_full, aclk, aresetn,
        m_valid_reg && (m_status_reg == STAT_FULL),
        m_count_reg == ECOUNT_W'(CAPACITY), "full reported below capacity")
    `OLID_ASSERT_NXT(a_path_by_func, aclk, aresetn, accept,
        (func_reg == FUNC_DELETE) == (state_reg == ST_WALK), "wrong path for request")

endmodule
